// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the covariance kernel RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/ecov_pkg.sv =====
// ----------------------------------------------------------------------------
// ecov_pkg
// Shared constants for the exponential covariance kernel.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ecov_pkg;

  // Field and register widths
  localparam int unsigned DataW       = 32;
  localparam int unsigned CfgIdxW     = 2;
  localparam int unsigned CoordWDef   = 32;

  // Register indexes
  localparam logic [CfgIdxW-1:0] CfgLengthScale    = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgSignalVariance = 2'd1;

  // Register reset values (1.0 in Q16.16)
  localparam logic [DataW-1:0] LengthScaleRst    = 32'h0001_0000;
  localparam logic [DataW-1:0] SignalVarianceRst = 32'h0001_0000;

  // Divider geometry: Q16.16 distance shifted up by 16, over a 33-bit divisor
  localparam int unsigned DivNumW = 48;
  localparam int unsigned DivDenW = 33;

  // Exponential evaluation
  localparam logic [32:0] OneQ32        = 33'h1_0000_0000;
  localparam logic [32:0] ExpNegOneQ32  = 33'd1580030169;
  localparam logic [3:0]  SeriesTerms   = 4'd12;
  localparam logic [31:0] ExpZeroInt    = 32'd23;

endpackage

`default_nettype wire

// ===== hw/rtl/ecov_in_if.sv =====
// ----------------------------------------------------------------------------
// ecov_in_if
// Input channel: one coordinate pair per transaction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface ecov_in_if;
  logic                           valid;
  logic                           ready;
  logic signed [ecov_pkg::DataW-1:0] a_coord;
  logic signed [ecov_pkg::DataW-1:0] b_coord;
  logic                           last_element;

  modport source (output valid, a_coord, b_coord, last_element, input ready);
  modport sink   (input valid, a_coord, b_coord, last_element, output ready);
endinterface

// Output channel: one kernel value per point pair
interface ecov_out_if;
  logic                       valid;
  logic                       ready;
  logic [ecov_pkg::DataW-1:0] covariance;
  logic                       sum_saturated;

  modport source (output valid, covariance, sum_saturated, input ready);
  modport sink   (input valid, covariance, sum_saturated, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/exponential_covariance_kernel_unit.sv =====
// ----------------------------------------------------------------------------
// exponential_covariance_kernel_unit
// variance * exp(-||A-B|| / (2*length_scale)) over streamed coordinate pairs.
// ----------------------------------------------------------------------------
// Each input transaction carries one coordinate pair; its squared difference
// is added to a saturating 64-bit sum (accept, square, add). On the
// transaction flagged last, a tail runs before the next transaction is
// taken: a square root of 32 steps, a divide by twice the length scale, 12
// series steps for exp of the fraction (each one multiply, one operand load
// and a pass of the shared divider), k multiplies by exp(-1) (k = integer
// part of the quotient, below 23), and a final variance multiply. When the
// integer part is 23 or more the series is skipped. One shared 33x33
// multiplier does all products. The result waits in an output register, so
// accumulation of the next pair may continue while it is pending; a second
// result stalls in its last cycle until the first is taken. Configuration
// must be written only while the block is idle; the block itself does not
// enforce this.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module exponential_covariance_kernel_unit #(
  parameter int unsigned COORD_WIDTH = ecov_pkg::CoordWDef
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_we_i,
  input  wire logic [ecov_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [ecov_pkg::DataW-1:0]   cfg_data_i,
  ecov_in_if.sink                           in_i,
  ecov_out_if.source                        out_o
);

  typedef enum logic [3:0] {
    ST_IDLE, ST_SQ, ST_ACC, ST_SQRT, ST_DIV, ST_SER_MUL, ST_SER_ST,
    ST_SER_DIV, ST_POW, ST_POW_UPD, ST_VAR_MUL, ST_FIN
  } state_e;

  state_e state_q;

  // Configuration registers
  logic [ecov_pkg::DataW-1:0] scale_q, var_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q <= ecov_pkg::LengthScaleRst;
      var_q   <= ecov_pkg::SignalVarianceRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        ecov_pkg::CfgLengthScale:    scale_q <= cfg_data_i;
        ecov_pkg::CfgSignalVariance: var_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Coordinate difference magnitude at accept
  logic signed [COORD_WIDTH:0] a_ext, b_ext, diff;
  logic [COORD_WIDTH-1:0]      mag;

  always_comb begin
    a_ext = {in_i.a_coord[COORD_WIDTH-1], in_i.a_coord[COORD_WIDTH-1:0]};
    b_ext = {in_i.b_coord[COORD_WIDTH-1], in_i.b_coord[COORD_WIDTH-1:0]};
    diff  = a_ext - b_ext;
    mag   = diff[COORD_WIDTH] ? COORD_WIDTH'(-diff) : diff[COORD_WIDTH-1:0];
  end

  logic in_acc;
  assign in_acc = in_i.valid && in_i.ready;

  // Working registers
  logic [COORD_WIDTH-1:0] mag_q;
  logic                   last_q;
  logic [63:0]            sum_q;
  logic                   sat_q;
  logic [31:0]            t_q;
  logic [32:0]            p_q;
  logic [3:0]             n_q;
  logic [4:0]             k_q;
  logic [65:0]            mul_q;
  logic                   out_vld_q, out_sat_q;
  logic [31:0]            out_cov_q;

  // Shared units
  logic        sqrt_start_q, sqrt_busy, sqrt_done;
  logic [31:0] root;
  logic        div_start_q, div_busy, div_done;
  logic [ecov_pkg::DivNumW-1:0] div_num_q, quo;
  logic [ecov_pkg::DivDenW-1:0] div_den_q;

  ecov_sqrt u_sqrt (
    .clk_i, .rst_ni,
    .start_i (sqrt_start_q),
    .rad_i   (sum_q),
    .busy_o  (sqrt_busy),
    .done_o  (sqrt_done),
    .root_o  (root)
  );

  ecov_div #(
    .NumW (ecov_pkg::DivNumW),
    .DenW (ecov_pkg::DivDenW)
  ) u_div (
    .clk_i, .rst_ni,
    .start_i (div_start_q),
    .num_i   (div_num_q),
    .den_i   (div_den_q),
    .busy_o  (div_busy),
    .done_o  (div_done),
    .quo_o   (quo)
  );

  // Shared multiplier: operand select and product register
  logic [32:0] mul_a, mul_b;
  logic        mul_en;

  always_comb begin
    mul_a  = '0;
    mul_b  = '0;
    mul_en = 1'b0;
    case (state_q)
      ST_SQ: begin
        mul_a  = 33'(mag_q);
        mul_b  = 33'(mag_q);
        mul_en = 1'b1;
      end
      ST_SER_MUL: begin
        mul_a  = {1'b0, t_q};
        mul_b  = p_q;
        mul_en = 1'b1;
      end
      ST_POW: begin
        mul_a  = p_q;
        mul_b  = ecov_pkg::ExpNegOneQ32;
        mul_en = (k_q != '0);
      end
      ST_VAR_MUL: begin
        mul_a  = {1'b0, var_q};
        mul_b  = p_q;
        mul_en = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mul_en) begin
      mul_q <= mul_a * mul_b;
    end
  end

  // Saturating accumulate
  logic [64:0] sum_add;
  assign sum_add = {1'b0, sum_q} + {1'b0, mul_q[63:0]};

  // Effective divisor: twice the scale, zero scale taken as one LSB
  logic [ecov_pkg::DivDenW-1:0] den2;
  assign den2 = (scale_q == '0) ? ecov_pkg::DivDenW'(2) : {scale_q, 1'b0};

  // Sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      mag_q        <= '0;
      last_q       <= 1'b0;
      sum_q        <= '0;
      sat_q        <= 1'b0;
      t_q          <= '0;
      p_q          <= '0;
      n_q          <= '0;
      k_q          <= '0;
      sqrt_start_q <= 1'b0;
      div_start_q  <= 1'b0;
      div_num_q    <= '0;
      div_den_q    <= '0;
      out_vld_q    <= 1'b0;
      out_sat_q    <= 1'b0;
      out_cov_q    <= '0;
    end else begin
      sqrt_start_q <= 1'b0;
      div_start_q  <= 1'b0;
      // Output taken; a result loaded in ST_FIN this cycle sets valid there
      if (out_vld_q && out_o.ready && (state_q != ST_FIN)) begin
        out_vld_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            mag_q   <= mag;
            last_q  <= in_i.last_element;
            state_q <= ST_SQ;
          end
        end
        ST_SQ: state_q <= ST_ACC;
        ST_ACC: begin
          if (sum_add[64]) begin
            sum_q <= '1;
            sat_q <= 1'b1;
          end else begin
            sum_q <= sum_add[63:0];
          end
          if (last_q) begin
            sqrt_start_q <= 1'b1;
            state_q      <= ST_SQRT;
          end else begin
            state_q <= ST_IDLE;
          end
        end
        ST_SQRT: begin
          if (sqrt_done) begin
            div_num_q   <= {root, 16'h0000};
            div_den_q   <= den2;
            div_start_q <= 1'b1;
            state_q     <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (div_done) begin
            t_q <= {quo[15:0], 16'h0000};
            n_q <= ecov_pkg::SeriesTerms;
            k_q <= quo[20:16];
            if (quo[47:16] >= ecov_pkg::ExpZeroInt) begin
              p_q     <= '0;
              state_q <= ST_VAR_MUL;
            end else begin
              p_q     <= ecov_pkg::OneQ32;
              state_q <= ST_SER_MUL;
            end
          end
        end
        ST_SER_MUL: state_q <= ST_SER_ST;
        ST_SER_ST: begin
          div_num_q   <= ecov_pkg::DivNumW'(mul_q[63:32]);
          div_den_q   <= ecov_pkg::DivDenW'(n_q);
          div_start_q <= 1'b1;
          state_q     <= ST_SER_DIV;
        end
        ST_SER_DIV: begin
          if (div_done) begin
            p_q <= ecov_pkg::OneQ32 - {1'b0, quo[31:0]};
            if (n_q == 4'd1) begin
              state_q <= ST_POW;
            end else begin
              n_q     <= n_q - 1'b1;
              state_q <= ST_SER_MUL;
            end
          end
        end
        ST_POW: begin
          state_q <= (k_q == '0) ? ST_VAR_MUL : ST_POW_UPD;
        end
        ST_POW_UPD: begin
          p_q     <= mul_q[64:32];
          k_q     <= k_q - 1'b1;
          state_q <= ST_POW;
        end
        ST_VAR_MUL: state_q <= ST_FIN;
        ST_FIN: begin
          if (!out_vld_q || out_o.ready) begin
            out_cov_q <= mul_q[63:32];
            out_sat_q <= sat_q;
            out_vld_q <= 1'b1;
            sum_q     <= '0;
            sat_q     <= 1'b0;
            state_q   <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign in_i.ready          = (state_q == ST_IDLE);
  assign out_o.valid         = out_vld_q;
  assign out_o.covariance    = out_cov_q;
  assign out_o.sum_saturated = out_sat_q;

  // Checks
  `ASSERT_IMPLIES(a_ready_units_idle, clk_i, rst_ni, in_i.ready, !div_busy && !sqrt_busy,
                  "input ready while a shared unit is busy")
  `ASSERT_IMPLIES(a_cov_le_var, clk_i, rst_ni, out_vld_q, out_cov_q <= var_q,
                  "covariance exceeds the variance")
  `ASSERT_NEXT(a_fin_clears_sum, clk_i, rst_ni, state_q == ST_FIN && !out_vld_q,
               sum_q == '0 && !sat_q && out_vld_q, "sum not cleared on result")

endmodule

`default_nettype wire

// ===== hw/rtl/ecov_div.sv =====
// ----------------------------------------------------------------------------
// ecov_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ecov_div #(
  parameter int unsigned NumW = ecov_pkg::DivNumW,
  parameter int unsigned DenW = ecov_pkg::DivDenW
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            start_i,
  input  wire logic [NumW-1:0] num_i,
  input  wire logic [DenW-1:0] den_i,
  output logic                 busy_o,
  output logic                 done_o,
  output logic [NumW-1:0]      quo_o
);

  localparam int unsigned CntW = $clog2(NumW + 1);

  logic            busy_q, done_q;
  logic [CntW-1:0] cnt_q;
  logic [DenW-1:0] rem_q, den_q;
  logic [NumW-1:0] quo_q;
  logic [DenW:0]   rem_sh, rem_sub;
  logic            fits;

  // Trial subtract of the divisor from the shifted partial remainder
  always_comb begin
    rem_sh  = {rem_q, quo_q[NumW-1]};
    rem_sub = rem_sh - {1'b0, den_q};
    fits    = rem_sh >= {1'b0, den_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CntW'(NumW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CntW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= num_i;
      den_q <= den_i;
    end else if (busy_q) begin
      rem_q <= fits ? rem_sub[DenW-1:0] : rem_sh[DenW-1:0];
      quo_q <= {quo_q[NumW-2:0], fits};
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

`default_nettype wire

// ===== hw/rtl/ecov_sqrt.sv =====
// ----------------------------------------------------------------------------
// ecov_sqrt
// Floor square root of a 64-bit value, two radicand bits per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ecov_sqrt (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [63:0] rad_i,
  output logic             busy_o,
  output logic             done_o,
  output logic [31:0]      root_o
);

  logic        busy_q, done_q;
  logic [5:0]  cnt_q;
  logic [63:0] rad_q;
  logic [33:0] rem_q;
  logic [31:0] root_q;
  logic [35:0] rem_sh, trial, rem_sub;
  logic        fits;

  // Trial value 4*root+1 against the shifted remainder
  always_comb begin
    rem_sh  = {rem_q, rad_q[63:62]};
    trial   = {2'b00, root_q, 2'b01};
    rem_sub = rem_sh - trial;
    fits    = rem_sh >= trial;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= 6'd32;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == 6'd1) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rad_q  <= rad_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      rad_q  <= {rad_q[61:0], 2'b00};
      rem_q  <= fits ? rem_sub[33:0] : rem_sh[33:0];
      root_q <= {root_q[30:0], fits};
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign root_o = root_q;

endmodule

`default_nettype wire

// ===== sim/ecov_checker.sv =====
// ----------------------------------------------------------------------------
// ecov_checker
// Watches both channels of the covariance kernel, predicts each kernel value
// from accepted coordinate pairs and compares it with the emitted result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ecov_checker #(
  parameter int unsigned COORD_WIDTH = 32
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [ecov_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [ecov_pkg::DataW-1:0]   cfg_data_i,
  input  logic                         in_valid_i,
  input  logic                         in_ready_i,
  input  logic [31:0]                  in_a_i,
  input  logic [31:0]                  in_b_i,
  input  logic                         in_last_i,
  input  logic                         out_valid_i,
  input  logic                         out_ready_i,
  input  logic [31:0]                  out_cov_i,
  input  logic                         out_sat_i,
  output int                           fail_count_o,
  output int                           pending_o
);
  import ecov_pkg::*;

  typedef struct packed {
    logic [31:0] covariance;
    logic        sum_saturated;
  } kernel_result_t;

  logic [31:0]    scale_q;
  logic [31:0]    variance_q;
  logic [63:0]    dist_sum;
  logic           sat_flag;
  kernel_result_t kernel_q[$];

  assign pending_o = kernel_q.size();

  function automatic longint coord_to_int(logic [31:0] raw);
    logic [63:0] v;
    v = 64'(raw) & ((64'd1 << COORD_WIDTH) - 1);
    if (v[COORD_WIDTH-1]) return longint'(v) - longint'(64'd1 << COORD_WIDTH);
    return longint'(v);
  endfunction

  function automatic logic [63:0] floor_sqrt(logic [63:0] x);
    logic [63:0] root;
    logic [63:0] bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (x >= root + bitv) begin
        x = x - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return root;
  endfunction

  // exp(-q), q in Q16.16, result in Q0.32
  function automatic logic [63:0] exp_neg(logic [63:0] q);
    logic [63:0] k;
    logic [63:0] t;
    logic [63:0] p;
    k = q >> 16;
    t = (q & 64'hFFFF) << 16;
    p = 64'(OneQ32);
    if (k >= 64'(ExpZeroInt)) return 0;
    for (int n = SeriesTerms; n >= 1; n--) p = 64'(OneQ32) - ((t * p) >> 32) / n;
    while (k > 0) begin
      p = (p * 64'(ExpNegOneQ32)) >> 32;
      k--;
    end
    return p;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    longint      diff;
    logic [63:0] mag;
    logic [63:0] sq;
    logic [63:0] sum;
    logic [63:0] scl;
    logic [63:0] qt;
    logic [63:0] factor;
    logic        sat;
    kernel_result_t exp_r;
    if (!rst_ni) begin
      scale_q      <= LengthScaleRst;
      variance_q   <= SignalVarianceRst;
      dist_sum     <= 0;
      sat_flag     <= 1'b0;
      fail_count_o <= 0;
      kernel_q.delete();
    end else begin
      // register writes
      if (cfg_we_i) begin
        if (cfg_idx_i == CfgLengthScale) scale_q <= cfg_data_i;
        else if (cfg_idx_i == CfgSignalVariance) variance_q <= cfg_data_i;
      end
      // input transaction: accumulate, and predict on the last pair
      if (in_valid_i && in_ready_i) begin
        diff = coord_to_int(in_a_i) - coord_to_int(in_b_i);
        mag  = diff < 0 ? 64'(-diff) : 64'(diff);
        sq   = mag * mag;
        sum  = dist_sum;
        sat  = sat_flag;
        if (sum > 64'hFFFF_FFFF_FFFF_FFFF - sq) begin
          sum = 64'hFFFF_FFFF_FFFF_FFFF;
          sat = 1'b1;
        end else begin
          sum = sum + sq;
        end
        if (in_last_i) begin
          scl    = (scale_q == 0) ? 64'd1 : 64'(scale_q);
          qt     = (floor_sqrt(sum) << 16) / (2 * scl);
          factor = exp_neg(qt);
          exp_r.covariance    = 32'((64'(variance_q) * factor) >> 32);
          exp_r.sum_saturated = sat;
          kernel_q.push_back(exp_r);
          sum = 0;
          sat = 1'b0;
        end
        dist_sum <= sum;
        sat_flag <= sat;
      end
      // output transaction: compare with oldest prediction
      if (out_valid_i && out_ready_i) begin
        if (kernel_q.size() == 0) begin
          if (fail_count_o < 10) $display("unexpected result cov=%h sat=%b", out_cov_i, out_sat_i);
          fail_count_o <= fail_count_o + 1;
        end else begin
          exp_r = kernel_q.pop_front();
          if (exp_r.covariance !== out_cov_i || exp_r.sum_saturated !== out_sat_i) begin
            if (fail_count_o < 10)
              $display("mismatch: expected cov=%h sat=%b, got cov=%h sat=%b",
                       exp_r.covariance, exp_r.sum_saturated, out_cov_i, out_sat_i);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
    end
  end
endmodule

// ===== sim/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Drives coordinate pairs and register settings into the covariance kernel
// with random idling and a long output stall; the checker scores results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import ecov_pkg::*;

  localparam int WatchdogLimit = 20000;
  localparam int TailCycles    = 1000;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i = '0;
  logic [DataW-1:0]   cfg_data_i = '0;
  logic               src_idle_en = 1'b1;
  logic               snk_idle_en = 1'b1;
  logic               hold_off = 1'b0;
  int                 fail_count;
  int                 pending;
  int                 idle_cycles = 0;

  ecov_in_if  in_ch();
  ecov_out_if out_ch();

  exponential_covariance_kernel_unit dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i, .in_i(in_ch), .out_o(out_ch)
  );

  ecov_checker chk (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_valid_i(in_ch.valid), .in_ready_i(in_ch.ready), .in_a_i(in_ch.a_coord),
    .in_b_i(in_ch.b_coord), .in_last_i(in_ch.last_element),
    .out_valid_i(out_ch.valid), .out_ready_i(out_ch.ready), .out_cov_i(out_ch.covariance),
    .out_sat_i(out_ch.sum_saturated), .fail_count_o(fail_count), .pending_o(pending)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.a_coord = '0;
    in_ch.b_coord = '0;
    in_ch.last_element = 1'b0;
    out_ch.ready = 1'b0;
  end

  // receiver: random stall bursts, plus a long hold-off on request
  initial begin
    int n;
    @(posedge rst_ni);
    forever begin
      if (hold_off) begin
        out_ch.ready <= 1'b0;
        for (n = 0; n < 3000; n++) @(posedge clk_i);
        hold_off = 1'b0;
      end else if (snk_idle_en && $urandom_range(0, 3) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk_i);
      end else begin
        out_ch.ready <= 1'b1;
        @(posedge clk_i);
      end
    end
  end

  // watchdog on accepted transactions
  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || hold_off)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchdogLimit) begin
      $display("FAIL exponential_covariance_kernel_unit");
      $finish;
    end
  end

  // valid stays high after the transaction; the next idle burst or drain drops it
  task automatic send_pair(logic [31:0] a, logic [31:0] b, logic last);
    if (src_idle_en && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk_i);
    end
    in_ch.valid        <= 1'b1;
    in_ch.a_coord      <= a;
    in_ch.b_coord      <= b;
    in_ch.last_element <= last;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [31:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // stop offering, wait for all results, then the block's tail latency
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
      2: return $urandom_range(0, 32'h0000_0800);
      default: return {$urandom_range(0, 1) ? 16'hFFFF : 16'h0000, 16'($urandom)};
    endcase
  endfunction

  initial begin
    logic [31:0] scales[5];
    logic [31:0] vars[5];
    logic [31:0] a;
    int len;
    int sent;
    logic held;
    held = 1'b0;
    scales = '{32'h0001_0000, 32'd1, 32'hFFFF_FFFF, 32'd0, 32'h0000_4000};
    vars   = '{32'h0001_0000, 32'hFFFF_FFFF, 32'd0, 32'h0003_8000, 32'd1};
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: equal points, extremes, saturation, multi-coordinate sets
    send_pair(32'h0, 32'h0, 1'b1);
    send_pair(32'h1234_5678, 32'h1234_5678, 1'b1);
    send_pair(32'h7FFF_FFFF, 32'h8000_0000, 1'b1);
    send_pair(32'h8000_0000, 32'h7FFF_FFFF, 1'b1);
    send_pair(32'h0001_0000, 32'h0, 1'b1);
    send_pair(32'h0, 32'h0002_0000, 1'b1);
    send_pair(32'hFFFF_FFFF, 32'h0000_0001, 1'b1);
    for (int i = 0; i < 6; i++) send_pair(32'h7FFF_FFFF, 32'h8000_0000, i == 5);
    send_pair(32'h0000_8000, 32'h0, 1'b0);
    send_pair(32'h0, 32'h0000_8000, 1'b0);
    send_pair(32'h0000_0100, 32'hFFFF_FF00, 1'b1);
    send_pair(32'h0016_0000, 32'h0, 1'b1);
    send_pair(32'h0017_0000, 32'h0, 1'b1);
    drain();
    write_reg(2'd3, 32'hDEAD_BEEF);

    // random phases over several register settings
    sent = 0;
    for (int ph = 0; ph < 5; ph++) begin
      write_reg(CfgLengthScale, scales[ph]);
      write_reg(CfgSignalVariance, vars[ph]);
      if (ph == 4) begin
        src_idle_en = 1'b0;
        snk_idle_en = 1'b0;
      end
      while (sent < (ph + 1) * 130) begin
        len = $urandom_range(1, 4);
        if (ph == 2 && sent >= 270 && !held) begin
          hold_off = 1'b1;
          held     = 1'b1;
        end
        for (int j = 0; j < len; j++) begin
          a = rand_coord();
          if ($urandom_range(0, 9) == 0) send_pair(a, a, j == len - 1);
          else send_pair(a, rand_coord(), j == len - 1);
          sent++;
        end
      end
      drain();
    end

    if (fail_count == 0)
      $display("PASS exponential_covariance_kernel_unit");
    else
      $display("FAIL exponential_covariance_kernel_unit");
    $finish;
  end
endmodule
